FILE: rtl/lir_pkg.sv
`default_nettype none

package lir_pkg;

   localparam int LEN_W       = 13;
   localparam int SAMPLE_W    = 16;
   localparam int STEP_W      = 24;
   localparam int ACC_W       = 32;
   localparam int MAX_RESULTS = 34;
   localparam int CNT_W       = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_IDX_W-1:0] REG_IN_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_RATIO = 2'd2;

   localparam logic [LEN_W-1:0] IN_LENGTH_RST  = 13'd1024;
   localparam logic [LEN_W-1:0] OUT_LENGTH_RST = 13'd1024;

   typedef struct packed {
      logic load;
      logic mul;
      logic emit_interp;
      logic emit_fill;
      logic emit_unit;
      logic finish;
   } lir_cmd_type;

   typedef struct packed {
      logic zero_len;
      logic unit_len;
      logic first;
      logic last;
      logic can_interp;
      logic can_fill;
      logic slot_free;
   } lir_status_type;

endpackage

`default_nettype wire

FILE: rtl/linear_interp_resampler_core.sv
`default_nettype none
// A transaction is taken in the idle state and decided in the next; each interpolated
// result passes the decide, multiply and round steps and each copied result the
// decide and emit steps, and an emit step waits while rsp_stall holds the output register.
// A new input is taken only back in idle; an input yields at most 34 results,
// interpolated and copied together; a unit-length block copies its first input once.
// Reset: synchronous; restores register defaults, block start and an empty output.

module linear_interp_resampler_core
   import lir_pkg::*;
#(
   parameter int MAX_BLOCK = 4096,
   parameter int FRAC_BITS = 16
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wr_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [SAMPLE_W-1:0] req_in_sample,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0]      rsp_out_sample,
   output logic                            rsp_last_of_run,
   output logic                            rsp_block_end
);

   lir_cmd_type    cmd;
   lir_status_type status;

   lir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lir_datapath #(
      .MAX_BLOCK (MAX_BLOCK),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_in_sample   (req_in_sample),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_block_end   (rsp_block_end),
      .cmd             (cmd),
      .status          (status)
   );

   // end of block always closes the run of its input
   a_block_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_last_of_run)
      else $error("block_end without last_of_run");

   // after a transaction is taken the core is busy deciding
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous transaction still in work");

   // a stalled result is never dropped
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result lost");

endmodule

`default_nettype wire

FILE: rtl/lir_ctrl.sv
`default_nettype none

module lir_ctrl
   import lir_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire lir_status_type status,
   output lir_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_MUL,
      S_EMIT_I,
      S_EMIT_F,
      S_EMIT_U
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.zero_len) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else if (status.unit_len) begin
               if (status.first) begin
                  state_in = S_EMIT_U;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else if (status.can_interp) begin
               state_in = S_MUL;
            end else if (status.last && status.can_fill) begin
               state_in = S_EMIT_F;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_EMIT_I;
         end
         S_EMIT_I: begin
            if (status.slot_free) begin
               cmd.emit_interp = 1'b1;
               state_in        = S_DECIDE;
            end
         end
         S_EMIT_F: begin
            if (status.slot_free) begin
               cmd.emit_fill = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_EMIT_U: begin
            if (status.slot_free) begin
               cmd.emit_unit = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/lir_datapath.sv
`default_nettype none

module lir_datapath
   import lir_pkg::*;
#(
   parameter int MAX_BLOCK = 4096,
   parameter int FRAC_BITS = 16
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wr_data,
   input  wire logic signed [SAMPLE_W-1:0] req_in_sample,
   input  wire logic                       rsp_stall,
   output logic                            rsp_valid,
   output logic signed [SAMPLE_W-1:0]      rsp_out_sample,
   output logic                            rsp_last_of_run,
   output logic                            rsp_block_end,
   input  wire lir_cmd_type                cmd,
   output lir_status_type                  status
);

   localparam int CMP_W  = (LEN_W + FRAC_BITS > ACC_W + 1) ? LEN_W + FRAC_BITS : ACC_W + 1;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
   localparam int NUM_W  = PROD_W + 1;
   localparam logic signed [NUM_W-1:0] HALF = NUM_W'(1) <<< (FRAC_BITS - 1);

   logic [LEN_W-1:0]           in_len_ff, out_len_ff;
   logic [STEP_W-1:0]          step_ff;
   logic signed [SAMPLE_W-1:0] prev_ff, cur_ff;
   logic [LEN_W-1:0]           ic_ff, oc_ff;
   logic [ACC_W-1:0]           acc_ff, acc_nxt_ff, acc_nxt_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_lor_ff, out_be_ff, out_lor_in, out_be_in;

   logic [LEN_W-1:0]  ilen, olen;
   logic [CMP_W-1:0]  limit, acc_cmp, acc_nxt_cmp;
   logic [LEN_W:0]    oc_inc;
   logic [CNT_W-1:0]  cnt_inc;
   logic              more_room, more;
   logic [ACC_W:0]    acc_sum;
   logic signed [DIFF_W-1:0] diff;
   logic signed [NUM_W-1:0]  num, mag, quo;

   // lengths above the block limit behave as the limit
   always_comb begin
      ilen = ({19'd0, in_len_ff} > MAX_BLOCK) ? LEN_W'(MAX_BLOCK) : in_len_ff;
      olen = ({19'd0, out_len_ff} > MAX_BLOCK) ? LEN_W'(MAX_BLOCK) : out_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_len_ff  <= IN_LENGTH_RST;
         out_len_ff <= OUT_LENGTH_RST;
         step_ff    <= STEP_W'(64'd1 << FRAC_BITS);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IN_LENGTH:  in_len_ff  <= csr_wr_data[LEN_W-1:0];
            REG_OUT_LENGTH: out_len_ff <= csr_wr_data[LEN_W-1:0];
            REG_STEP_RATIO: step_ff    <= csr_wr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign limit       = CMP_W'(ic_ff) << FRAC_BITS;
   assign acc_cmp     = CMP_W'(acc_ff);
   assign acc_nxt_cmp = CMP_W'(acc_nxt_ff);
   assign oc_inc      = {1'b0, oc_ff} + 1'b1;
   assign cnt_inc     = cnt_ff + 1'b1;

   always_comb begin
      status.zero_len   = (ilen == '0) || (olen == '0);
      status.unit_len   = (ilen == LEN_W'(1)) || (olen == LEN_W'(1));
      status.first      = (ic_ff == '0);
      status.last       = (({1'b0, ic_ff} + 1'b1) >= {1'b0, ilen});
      status.can_fill   = (oc_ff < olen) && (cnt_ff < CNT_W'(MAX_RESULTS));
      status.can_interp = status.can_fill && (acc_cmp < limit);
      status.slot_free  = !out_valid_ff || !rsp_stall;
   end

   // position step with saturation, and the weighted difference
   always_comb begin
      acc_sum    = {1'b0, acc_ff} + (ACC_W + 1)'(step_ff);
      acc_nxt_in = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
      diff       = DIFF_W'(cur_ff) - DIFF_W'(prev_ff);
      prod_in    = PROD_W'(diff) * $signed({1'b0, acc_ff[FRAC_BITS-1:0]});
   end

   // prev + weighted difference + half, truncated toward zero
   always_comb begin
      num = (NUM_W'(prev_ff) <<< FRAC_BITS) + NUM_W'(prod_ff) + HALF;
      mag = num[NUM_W-1] ? -num : num;
      quo = mag >>> FRAC_BITS;
      if (num[NUM_W-1]) begin
         quo = -quo;
      end
   end

   always_comb begin
      more_room = (oc_inc < {1'b0, olen}) && (cnt_inc < CNT_W'(MAX_RESULTS));
      more      = more_room && (!cmd.emit_interp || (acc_nxt_cmp < limit) || status.last);
      out_sample_in = cur_ff;
      out_lor_in    = !more;
      out_be_in     = (oc_inc == {1'b0, olen}) || (status.last && !more);
      if (cmd.emit_interp) begin
         out_sample_in = quo[SAMPLE_W-1:0];
      end
      if (cmd.emit_unit) begin
         out_lor_in = 1'b1;
         out_be_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         ic_ff   <= '0;
         oc_ff   <= '0;
         acc_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         if (cmd.load) begin
            cnt_ff <= '0;
         end
         if (cmd.emit_interp) begin
            oc_ff  <= oc_inc[LEN_W-1:0];
            cnt_ff <= cnt_inc;
            acc_ff <= acc_nxt_ff;
         end
         if (cmd.emit_fill) begin
            oc_ff  <= oc_inc[LEN_W-1:0];
            cnt_ff <= cnt_inc;
         end
         if (cmd.finish) begin
            prev_ff <= cur_ff;
            if (status.zero_len || status.last) begin
               ic_ff  <= '0;
               oc_ff  <= '0;
               acc_ff <= '0;
            end else begin
               ic_ff <= ic_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff <= req_in_sample;
      end
      if (cmd.mul) begin
         prod_ff    <= prod_in;
         acc_nxt_ff <= acc_nxt_in;
      end
   end

   // output register: one transaction held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_interp || cmd.emit_fill || cmd.emit_unit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_interp || cmd.emit_fill || cmd.emit_unit) begin
         out_sample_ff <= out_sample_in;
         out_lor_ff    <= out_lor_in;
         out_be_ff     <= out_be_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_sample  = out_sample_ff;
   assign rsp_last_of_run = out_lor_ff;
   assign rsp_block_end   = out_be_ff;

endmodule

`default_nettype wire

FILE: tb/tb_linear_interp_resampler_core.sv
`default_nettype none

module tb_linear_interp_resampler_core;
   import lir_pkg::*;

   localparam int MAX_BLOCK     = 4096;
   localparam int FRAC_BITS     = 16;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 280;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_of_run;
      logic                       block_end;
   } out_item_type;

   class resample_scoreboard;
      logic [LEN_W-1:0]  in_len;
      logic [LEN_W-1:0]  out_len;
      logic [STEP_W-1:0] step;
      longint            prev;
      int unsigned       in_cnt;
      int unsigned       out_cnt;
      longint unsigned   pos;
      out_item_type      pending_out[$];
      int                mismatches;
      int                checked;

      function new();
         in_len     = IN_LENGTH_RST;
         out_len    = OUT_LENGTH_RST;
         step       = STEP_W'(1 << FRAC_BITS);
         prev       = 0;
         in_cnt     = 0;
         out_cnt    = 0;
         pos        = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_IN_LENGTH: begin
               in_len = data[LEN_W-1:0];
            end
            REG_OUT_LENGTH: begin
               out_len = data[LEN_W-1:0];
            end
            REG_STEP_RATIO: begin
               step = data[STEP_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // prev*(1-d) + cur*d + 1/2, truncated toward zero
      function longint blend(longint a, longint b, longint unsigned f);
         longint num;
         num = a * (longint'(1) << FRAC_BITS) + (b - a) * longint'(f)
               + (longint'(1) << (FRAC_BITS - 1));
         if (num >= 0)
            return num >>> FRAC_BITS;
         return -((-num) >>> FRAC_BITS);
      endfunction

      function void take_sample(logic signed [SAMPLE_W-1:0] s);
         int unsigned     ilen;
         int unsigned     olen;
         longint          cur;
         longint          v;
         longint unsigned lim;
         bit              fin;
         out_item_type    run[$];
         out_item_type    item;
         ilen = (in_len > MAX_BLOCK) ? MAX_BLOCK : in_len;
         olen = (out_len > MAX_BLOCK) ? MAX_BLOCK : out_len;
         cur  = s;
         if (ilen == 0 || olen == 0) begin
            in_cnt  = 0;
            out_cnt = 0;
            pos     = 0;
            prev    = cur;
            return;
         end
         fin = (in_cnt + 1 >= ilen);
         if (ilen == 1 || olen == 1) begin
            if (in_cnt == 0) begin
               item.sample      = s;
               item.last_of_run = 1'b0;
               item.block_end   = 1'b1;
               run.push_back(item);
            end
         end else begin
            lim = longint'(in_cnt) << FRAC_BITS;
            while (out_cnt < olen && run.size() < MAX_RESULTS && pos < lim) begin
               v = blend(prev, cur, pos & ((longint'(1) << FRAC_BITS) - 1));
               item.sample      = v[SAMPLE_W-1:0];
               item.last_of_run = 1'b0;
               item.block_end   = (out_cnt + 1 == olen);
               run.push_back(item);
               out_cnt++;
               pos += step;
               if (pos > 64'hFFFF_FFFF)
                  pos = 64'hFFFF_FFFF;
            end
            if (fin) begin
               // outputs at or past the last sample copy it; the cap drops the rest
               while (out_cnt < olen && run.size() < MAX_RESULTS) begin
                  item.sample      = s;
                  item.last_of_run = 1'b0;
                  item.block_end   = (out_cnt + 1 == olen);
                  run.push_back(item);
                  out_cnt++;
               end
               if (run.size() > 0)
                  run[run.size()-1].block_end = 1'b1;
            end
         end
         if (run.size() > 0)
            run[run.size()-1].last_of_run = 1'b1;
         prev = cur;
         if (fin) begin
            in_cnt  = 0;
            out_cnt = 0;
            pos     = 0;
         end else begin
            in_cnt++;
         end
         foreach (run[i])
            pending_out.push_back(run[i]);
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] s, logic lr, logic be);
         out_item_type e;
         if (pending_out.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual sample %0d last %0b end %0b",
                     $time, s, lr, be);
            mismatches++;
            return;
         end
         e = pending_out.pop_front();
         checked++;
         if (s !== e.sample) begin
            $display("%0t: out_sample mismatch, expected %0d, actual %0d", $time, e.sample, s);
            mismatches++;
         end
         if (lr !== e.last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                     $time, e.last_of_run, lr);
            mismatches++;
         end
         if (be !== e.block_end) begin
            $display("%0t: block_end mismatch, expected %0b, actual %0b",
                     $time, e.block_end, be);
            mismatches++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wr_data;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_in_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic                       rsp_last_of_run;
   logic                       rsp_block_end;

   resample_scoreboard sb;
   bit                 calm;
   bit                 hold_off_req;
   int                 sent;
   int                 settings;

   linear_interp_resampler_core #(
      .MAX_BLOCK (MAX_BLOCK),
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_sample   (req_in_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_block_end   (rsp_block_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // valid stays high across back-to-back transactions; lowered only for a gap or a drain
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_sample <= s;
      do
         @(posedge clock);
      while (req_stall);
      sb.take_sample(s);
      sent++;
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending_out.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // a sample with no output may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic program_regs(input int unsigned il, input int unsigned ol,
                               input int unsigned st);
      logic [CSR_DATA_W-1:0] data;
      data            = CSR_DATA_W'($urandom);
      data[LEN_W-1:0] = LEN_W'(il);
      csr_write(REG_IN_LENGTH, data);
      data            = CSR_DATA_W'($urandom);
      data[LEN_W-1:0] = LEN_W'(ol);
      csr_write(REG_OUT_LENGTH, data);
      csr_write(REG_STEP_RATIO, CSR_DATA_W'(st));
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   initial begin : rsp_side
      int hold;
      int seen;
      bit rsp_calm;
      hold     = 0;
      seen     = 0;
      rsp_calm = 1'b0;
      rsp_stall <= 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_out_sample, rsp_last_of_run, rsp_block_end);
            seen++;
            if (seen % 40 == 0)
               rsp_calm = ($urandom_range(0, 2) == 0);
            hold = rsp_calm ? 0 : $urandom_range(0, 12);
         end else if (hold > 0) begin
            hold--;
         end
         if (hold_off_req) begin
            hold         = LONG_HOLD;
            hold_off_req = 1'b0;
         end
         rsp_stall <= (hold > 0);
      end
   end

   initial begin : stimulus
      int unsigned il;
      int unsigned ol;
      int unsigned st;
      int unsigned n;
      int          kind;
      int          random_items;
      bit          hold_done;
      logic signed [SAMPLE_W-1:0] s;
      sb           = new();
      calm         = 1'b0;
      hold_off_req = 1'b0;
      sent         = 0;
      settings     = 0;
      random_items = 0;
      hold_done    = 1'b0;
      req_valid     <= 1'b0;
      req_in_sample <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= REG_IN_LENGTH;
      csr_wr_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults, unit step between full-scale samples
      send_sample(SMP_MAX);
      send_sample(SMP_MIN);
      send_sample(SMP_MAX);
      send_sample(-16'sd1);
      send_sample(16'sd0);

      // half step: rounding of odd sums, both signs
      drain();
      program_regs(5, 9, 32768);
      send_sample(SMP_MIN);
      send_sample(SMP_MAX);
      send_sample(-16'sd3);
      send_sample(16'sd2);
      send_sample(SMP_MAX);

      // unit lengths
      drain();
      program_regs(1, 7, 65536);
      send_sample(SMP_MIN);
      drain();
      program_regs(6, 1, 65536);
      send_sample(16'sd12345);
      send_sample(-16'sd5);

      // oversized lengths, a fine step of 1/32
      drain();
      program_regs(8191, 5000, 2048);
      send_sample(SMP_MAX);
      send_sample(SMP_MIN);
      send_sample(16'sd100);

      // zero input length
      drain();
      program_regs(0, 5, 2048);
      send_sample(-16'sd1);

      // zero step: every sample after the first hits the result cap, also the last one
      drain();
      csr_write(REG_UNUSED, 24'hFFFFFF);
      program_regs(3, 4096, 0);
      send_sample(SMP_MAX);
      send_sample(SMP_MIN);
      send_sample(SMP_MAX);

      // zero output length
      drain();
      program_regs(4, 0, 65536);
      send_sample(16'sd7);

      // coarsest step: everything past the end copies the last sample
      drain();
      program_regs(4, 4, 24'hFFFFFF);
      send_sample(SMP_MIN);
      send_sample(SMP_MAX);
      send_sample(16'sd1);
      send_sample(SMP_MIN);

      while (random_items < RANDOM_ITEMS) begin
         drain();
         if (!hold_done) begin
            // heavy upsampling with the output side held off
            il   = 20;
            ol   = 400;
            st   = (19 << FRAC_BITS) / 399;
            n    = 40;
            calm = 1'b1;
         end else begin
            kind = $urandom_range(0, 99);
            calm = ($urandom_range(0, 3) == 0);
            if (kind < 70) begin
               il = $urandom_range(2, 24);
               ol = $urandom_range(2, (32 * (il - 1) + 1 < 48) ? 32 * (il - 1) + 1 : 48);
               st = ((il - 1) << FRAC_BITS) / (ol - 1);
               if ($urandom_range(0, 9) == 0)
                  st = st + $urandom_range(0, 64) - 32;
               n  = $urandom_range(il, 3 * il);
            end else if (kind < 80) begin
               il = $urandom_range(0, 40);
               ol = $urandom_range(0, 80);
               st = $urandom_range(0, 1) ? $urandom_range(0, 1 << 18)
                                         : $urandom_range(0, 24'hFFFFFF);
               n  = $urandom_range(1, 40);
            end else if (kind < 90) begin
               if ($urandom_range(0, 1)) begin
                  il = 1;
                  ol = $urandom_range(1, 50);
               end else begin
                  il = $urandom_range(1, 20);
                  ol = 1;
               end
               st = $urandom_range(0, 1 << 17);
               n  = $urandom_range(2, 2 * il + 2);
            end else if (kind < 95) begin
               // long blocks left unfinished; the next setting cuts them short
               il = $urandom_range(1000, 8191);
               ol = $urandom_range(1000, 8191);
               st = $urandom_range(2048, 1 << 18);
               n  = $urandom_range(4, 12);
            end else begin
               il = $urandom_range(0, 1) ? 0 : $urandom_range(0, 30);
               ol = (il == 0) ? $urandom_range(0, 30) : 0;
               st = $urandom_range(0, 24'hFFFFFF);
               n  = $urandom_range(1, 6);
            end
         end
         program_regs(il, ol, st);
         if (!hold_done) begin
            hold_off_req = 1'b1;
            hold_done    = 1'b1;
         end
         repeat (n) begin
            case ($urandom_range(0, 7))
               0: s = SMP_MAX;
               1: s = SMP_MIN;
               default: s = SAMPLE_W'($urandom);
            endcase
            send_sample(s);
         end
         if (il != 0 && ol != 0)
            random_items += n;
      end

      drain();
      if (sb.pending_out.size() != 0) begin
         $display("%0t: %0d expected output samples never arrived",
                  $time, sb.pending_out.size());
         sb.mismatches += sb.pending_out.size();
      end
      $display("Sent %0d input samples over %0d register settings, checked %0d outputs.",
               sent, settings, sb.checked);
      $display("Covered unit, zero and oversized lengths, zero and full-scale steps,");
      $display("the result cap and a long output stall.");
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Timed out waiting on the resampler.");
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

FILE: linear_interp_resampler_core.f
rtl/lir_pkg.sv
rtl/lir_ctrl.sv
rtl/lir_datapath.sv
rtl/linear_interp_resampler_core.sv
tb/tb_linear_interp_resampler_core.sv
